[src/jdd_pkg.sv]
// Shared types and constants for the joystick direction debouncer.
// Holds the direction codes, the register map and the register reset values.
// Depends on nothing.
`default_nettype none

package jdd_pkg;

  // Direction codes as they appear on the result port
  typedef enum logic [2:0] {
    MOVE_NONE  = 3'd0,
    MOVE_UP    = 3'd1,
    MOVE_DOWN  = 3'd2,
    MOVE_LEFT  = 3'd3,
    MOVE_RIGHT = 3'd4
  } dir_t;

  // Register index, taken from the word address of the register port
  typedef enum logic [2:0] {
    REG_CENTER    = 3'd0,
    REG_DEADZONE  = 3'd1,
    REG_THRESH_LO = 3'd2,
    REG_THRESH_HI = 3'd3,
    REG_HOLDOFF   = 3'd4
  } cfg_reg_t;

  localparam int CfgAddrBits  = 5;
  localparam int CfgDataBits  = 32;
  localparam int TimeBits     = 32;
  localparam int HoldoffBits  = 16;
  // Sample-valued register fields are never wider than this, whatever the sample width
  localparam int FieldBits    = 12;

  localparam int CenterReset  = 2048;
  localparam int DeadzoneReset = 500;
  localparam int ThreshLoReset = 1000;
  localparam int ThreshHiReset = 3000;
  localparam int HoldoffReset  = 100;

endpackage

`default_nettype wire

[src/joystick_direction_debouncer.sv]
// Joystick direction classifier with hold-off debouncing, top level.
// Uses jdd_pkg for direction codes, the register map and reset values.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-------------------------------------
//   input     | in_valid, in_stall | mode, x_sample, y_sample, now_ms
//   result    | out_valid,out_stall| direction, suppressed
//   registers | APB psel/penable   | paddr, pwdata, prdata
//
// One request per cycle is accepted while in_stall is low; its result is
// presented through the input register, then the result register. The classify
// compares and the 32-bit elapsed-time subtract sit in the single stage between
// them, and the held direction and change time update as the result register loads.
// Reset (rst, synchronous) clears the pipeline valids, the held direction and
// the change time, and loads the registers with their reset values. A stalled result
// holds the result register; the input register then holds and in_stall rises.
`default_nettype none

module joystick_direction_debouncer #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          mode,
  input  wire logic [SAMPLE_BITS-1:0]        x_sample,
  input  wire logic [SAMPLE_BITS-1:0]        y_sample,
  input  wire logic [jdd_pkg::TimeBits-1:0]  now_ms,
  // result channel
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [2:0]                    direction,
  output      logic                          suppressed,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jdd_pkg::CfgAddrBits-1:0] paddr,
  input  wire logic [jdd_pkg::CfgDataBits-1:0] pwdata,
  output      logic [jdd_pkg::CfgDataBits-1:0] prdata,
  output      logic                          pready
);

  localparam int UsedBits = (SAMPLE_BITS < jdd_pkg::FieldBits) ?
                            SAMPLE_BITS : jdd_pkg::FieldBits;
  localparam logic [SAMPLE_BITS-1:0] SampleMask =
    SAMPLE_BITS'((64'd1 << UsedBits) - 64'd1);

  // Configuration registers
  logic [SAMPLE_BITS-1:0]             center_value;
  logic [SAMPLE_BITS-1:0]             deadzone;
  logic [SAMPLE_BITS-1:0]             threshold_low;
  logic [SAMPLE_BITS-1:0]             threshold_high;
  logic [jdd_pkg::HoldoffBits-1:0]    holdoff_ms;

  // Input register
  logic                               s1_valid;
  logic                               s1_mode;
  logic [SAMPLE_BITS-1:0]             s1_x;
  logic [SAMPLE_BITS-1:0]             s1_y;
  logic [jdd_pkg::TimeBits-1:0]       s1_now;

  // Debounce state
  jdd_pkg::dir_t                      held_direction;
  logic [jdd_pkg::TimeBits-1:0]       last_change_ms;

  // Stage logic
  logic                               out_free;
  logic                               advance;
  logic [SAMPLE_BITS:0]               dx;
  logic [SAMPLE_BITS:0]               dy;
  logic [SAMPLE_BITS:0]               dx_abs;
  logic [SAMPLE_BITS:0]               dy_abs;
  logic [SAMPLE_BITS-1:0]             ax;
  logic [SAMPLE_BITS-1:0]             ay;
  jdd_pkg::dir_t                      raw_dir;
  jdd_pkg::dir_t                      fin_dir;
  logic                               fin_supp;
  logic                               take_time;
  logic [jdd_pkg::TimeBits-1:0]       elapsed;
  logic                               cfg_write;
  jdd_pkg::cfg_reg_t                  cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_index = jdd_pkg::cfg_reg_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      center_value   <= SAMPLE_BITS'(jdd_pkg::CenterReset) & SampleMask;
      deadzone       <= SAMPLE_BITS'(jdd_pkg::DeadzoneReset) & SampleMask;
      threshold_low  <= SAMPLE_BITS'(jdd_pkg::ThreshLoReset) & SampleMask;
      threshold_high <= SAMPLE_BITS'(jdd_pkg::ThreshHiReset) & SampleMask;
      holdoff_ms     <= jdd_pkg::HoldoffBits'(jdd_pkg::HoldoffReset);
    end else if (cfg_write) begin
      unique case (cfg_index)
        jdd_pkg::REG_CENTER: begin
          center_value <= SAMPLE_BITS'(pwdata) & SampleMask;
        end
        jdd_pkg::REG_DEADZONE: begin
          deadzone <= SAMPLE_BITS'(pwdata) & SampleMask;
        end
        jdd_pkg::REG_THRESH_LO: begin
          threshold_low <= SAMPLE_BITS'(pwdata) & SampleMask;
        end
        jdd_pkg::REG_THRESH_HI: begin
          threshold_high <= SAMPLE_BITS'(pwdata) & SampleMask;
        end
        jdd_pkg::REG_HOLDOFF: begin
          holdoff_ms <= pwdata[jdd_pkg::HoldoffBits-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_index)
      jdd_pkg::REG_CENTER:    prdata = jdd_pkg::CfgDataBits'(center_value);
      jdd_pkg::REG_DEADZONE:  prdata = jdd_pkg::CfgDataBits'(deadzone);
      jdd_pkg::REG_THRESH_LO: prdata = jdd_pkg::CfgDataBits'(threshold_low);
      jdd_pkg::REG_THRESH_HI: prdata = jdd_pkg::CfgDataBits'(threshold_high);
      jdd_pkg::REG_HOLDOFF:   prdata = jdd_pkg::CfgDataBits'(holdoff_ms);
      default:                prdata = '0;
    endcase
  end

  // Pipeline flow: the result register frees when empty or being taken
  assign out_free = ~out_valid | ~out_stall;
  assign advance  = s1_valid & out_free;
  assign in_stall = s1_valid & ~out_free;

  // Capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode <= mode;
      s1_x    <= x_sample & SampleMask;
      s1_y    <= y_sample & SampleMask;
      s1_now  <= now_ms;
    end
  end

  // Offset magnitudes from the rest position
  always_comb begin
    dx     = {1'b0, s1_x} - {1'b0, center_value};
    dy     = {1'b0, s1_y} - {1'b0, center_value};
    dx_abs = dx[SAMPLE_BITS] ? -dx : dx;
    dy_abs = dy[SAMPLE_BITS] ? -dy : dy;
    ax     = dx_abs[SAMPLE_BITS-1:0];
    ay     = dy_abs[SAMPLE_BITS-1:0];
  end

  // Classify: deadzone, then dominant axis (tie to vertical), low compare first
  always_comb begin
    raw_dir = jdd_pkg::MOVE_NONE;
    if (ax < deadzone && ay < deadzone) begin
      raw_dir = jdd_pkg::MOVE_NONE;
    end else if (ax > ay) begin
      if (s1_x < threshold_low) begin
        raw_dir = jdd_pkg::MOVE_LEFT;
      end else if (s1_x > threshold_high) begin
        raw_dir = jdd_pkg::MOVE_RIGHT;
      end
    end else begin
      if (s1_y < threshold_low) begin
        raw_dir = jdd_pkg::MOVE_DOWN;
      end else if (s1_y > threshold_high) begin
        raw_dir = jdd_pkg::MOVE_UP;
      end
    end
  end

  // Hold back a new direction that comes inside the hold-off window
  assign elapsed = s1_now - last_change_ms;

  always_comb begin
    fin_dir   = raw_dir;
    fin_supp  = 1'b0;
    take_time = 1'b0;
    if (s1_mode && raw_dir != jdd_pkg::MOVE_NONE && raw_dir != held_direction) begin
      if (elapsed < jdd_pkg::TimeBits'(holdoff_ms)) begin
        fin_dir  = held_direction;
        fin_supp = 1'b1;
      end else begin
        take_time = 1'b1;
      end
    end
  end

  // Update the debounce state as the result loads
  always_ff @(posedge clk) begin
    if (rst) begin
      held_direction <= jdd_pkg::MOVE_NONE;
      last_change_ms <= '0;
    end else if (advance) begin
      held_direction <= fin_dir;
      if (take_time) begin
        last_change_ms <= s1_now;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      direction  <= fin_dir;
      suppressed <= fin_supp;
    end
  end

endmodule

`default_nettype wire
